[design/iirdf2_pkg.sv]
// Package for the transposed direct-form II IIR filter unit.
// Holds the item structs, command and accumulator codes, and the fixed-point limits.
// Depends on nothing; every other design file imports it.
package iirdf2_pkg;

  // Field widths fixed by the item format.
  localparam int CMD_W  = 2;
  localparam int TAP_W  = 4;
  localparam int COEF_W = 32;
  localparam int SAMP_W = 16;
  localparam int CFG_W  = 4;

  // Datapath widths: Q9.39 products, Q17.39 delay words, accumulator with headroom.
  localparam int PROD_W = COEF_W + SAMP_W;
  localparam int DW     = 56;
  localparam int ACC_W  = 58;

  // Output rounding: Q17.39 sum to Q1.15 sample.
  localparam int Y_SHIFT = 24;

  // Item commands.
  localparam logic [CMD_W-1:0] CMD_FILTER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_B   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WR_A   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  // Reset value of the active order register.
  localparam logic [CFG_W-1:0] ORDER_CFG_RST = 4'd2;

  // Saturation limits.
  localparam logic signed [DW-1:0]     DW_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0]     DW_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [SAMP_W-1:0] Y_MAX  = {1'b0, {(SAMP_W-1){1'b1}}};
  localparam logic signed [SAMP_W-1:0] Y_MIN  = {1'b1, {(SAMP_W-1){1'b0}}};

  // Accumulator operations applied to the registered product.
  typedef logic [1:0] acc_op_t;
  localparam acc_op_t ACC_HOLD = 2'd0;
  localparam acc_op_t ACC_LOAD = 2'd1;
  localparam acc_op_t ACC_SUB  = 2'd2;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic    mul_en;
    acc_op_t acc_op;
  } mac_ctl_t;

  typedef logic [CFG_W-1:0] order_cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [TAP_W-1:0]         tap_index;
    logic signed [COEF_W-1:0] coefficient;
    logic signed [SAMP_W-1:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMP_W-1:0] filtered_sample;
    logic                     saturated;
  } out_item_t;

endpackage

[design/iirdf2_mac.sv]
// Shared IIR multiply-accumulate: one 32x16 product per cycle while mul_en is set.
// The product is registered, then added to a new addend or subtracted from the sum.
// Depends on iirdf2_pkg.
module iirdf2_mac (
  input  logic                                   clk,
  input  iirdf2_pkg::mac_ctl_t                   ctl,
  input  logic signed [iirdf2_pkg::COEF_W-1:0]   coef,
  input  logic signed [iirdf2_pkg::SAMP_W-1:0]   mult,
  input  logic signed [iirdf2_pkg::DW-1:0]       addend,
  output logic signed [iirdf2_pkg::ACC_W-1:0]    acc
);
  import iirdf2_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;

  // Multiplier stage.
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= coef * mult;
    end
  end

  // Accumulator update from the registered product.
  always_comb begin
    case (ctl.acc_op)
      ACC_LOAD: acc_nxt = ACC_W'(addend) + ACC_W'(prod_r);
      ACC_SUB:  acc_nxt = acc_r - ACC_W'(prod_r);
      default:  acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

[design/iir_filter_df2_transposed_unit.sv]
// Top level of the transposed direct-form II IIR filter: sequencer, coefficient
// and delay stores, output register. Depends on iirdf2_pkg and iirdf2_mac.
//
//   Channel | Direction | Handshake          | Payload
//   in_     | input     | in_valid/in_stall   | in_item_t
//   out_    | output    | out_valid/out_stall | out_item_t
//   cfg_    | input     | cfg_valid/cfg_ready | active order, 4 bits
//
// A filter command with n active delay words runs n + 1 taps through the
// shared multiplier, which makes two products per tap in states MB, MA, AC and WB.
// Coefficient writes and the delay clear do not stall the input.
// Reset (synchronous, rst_n low) zeroes both coefficient stores and the delay line
// through valid bits, and sets the active order to 2.
// A result waiting in the output register holds; a new item is still taken meanwhile.
module iir_filter_df2_transposed_unit #(
  parameter int ORDER = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  iirdf2_pkg::in_item_t          in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output iirdf2_pkg::out_item_t         out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  iirdf2_pkg::order_cfg_t        cfg_data
);
  import iirdf2_pkg::*;

  localparam int KW  = $clog2(ORDER + 1);
  localparam int DAW = (ORDER > 1) ? $clog2(ORDER) : 1;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (Y_SHIFT - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MB   = 3'd1;
  localparam logic [2:0] S_MA   = 3'd2;
  localparam logic [2:0] S_AC   = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]               state_r, state_nxt;
  logic [KW-1:0]            k_r, k_nxt;
  logic [KW-1:0]            n_r, n_nxt;
  logic signed [SAMP_W-1:0] x_r, x_nxt;
  logic signed [SAMP_W-1:0] y_r, y_nxt;
  logic                     flag_r, flag_nxt;
  order_cfg_t               cfg_order_r;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  logic                     in_acc;
  logic                     tap_ok;
  logic [KW-1:0]            n_eff;
  logic [KW-1:0]            n_cur;
  logic [KW-1:0]            rd_k;
  logic                     rd_en;
  logic                     d_rd_en;
  logic [KW-1:0]            wa;
  logic                     b_we, a_we, d_we, d_clr;
  logic [DAW-1:0]           d_wa;

  logic signed [COEF_W-1:0] b_mem [0:ORDER];
  logic signed [COEF_W-1:0] a_mem [0:ORDER];
  logic signed [DW-1:0]     d_mem [0:ORDER-1];
  logic [ORDER:0]           b_vld_r, a_vld_r;
  logic [ORDER-1:0]         d_vld_r;
  logic signed [COEF_W-1:0] b_q_r, a_q_r;
  logic signed [DW-1:0]     d_q_r;
  logic                     b_v_r, a_v_r, d_v_r, dsel_r;

  logic signed [COEF_W-1:0] b_val, a_val;
  logic signed [DW-1:0]     dterm;

  mac_ctl_t                 mac_ctl;
  logic signed [COEF_W-1:0] mac_coef;
  logic signed [SAMP_W-1:0] mac_mult;
  logic signed [ACC_W-1:0]  acc;

  logic signed [ACC_W-1:0]  y_sum, y_full;
  logic signed [SAMP_W-1:0] y_sat;
  logic                     y_clip;
  logic signed [DW-1:0]     d_clip;
  logic                     d_clipped;

  // Handshakes.
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Active order clamped to 1..ORDER.
  always_comb begin
    if (cfg_order_r == '0) begin
      n_eff = KW'(1);
    end else if (32'(cfg_order_r) > ORDER) begin
      n_eff = KW'(ORDER);
    end else begin
      n_eff = KW'(cfg_order_r);
    end
  end

  // Coefficient write decode.
  assign tap_ok = (32'(in_data.tap_index) <= ORDER);
  assign wa     = KW'(in_data.tap_index);
  assign b_we   = in_acc && (in_data.command == CMD_WR_B) && tap_ok;
  assign a_we   = in_acc && (in_data.command == CMD_WR_A) && tap_ok &&
                  (in_data.tap_index != '0);
  assign d_clr  = in_acc && (in_data.command == CMD_CLEAR);

  // Store reads: tap zero on acceptance, the next tap during write-back.
  assign n_cur   = (state_r == S_IDLE) ? n_eff : n_r;
  assign rd_k    = (state_r == S_IDLE) ? '0 : k_r + 1'b1;
  assign rd_en   = (in_acc && (in_data.command == CMD_FILTER)) ||
                   ((state_r == S_WB) && (k_r != n_r));
  assign d_rd_en = rd_en && (rd_k < n_cur);

  // Delay word write-back for taps one and above.
  assign d_we = (state_r == S_WB) && (k_r != '0);
  assign d_wa = DAW'(k_r - 1'b1);

  // Coefficient stores.
  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[wa] <= in_data.coefficient;
    end
    if (a_we) begin
      a_mem[wa] <= in_data.coefficient;
    end
    if (rd_en) begin
      b_q_r <= b_mem[rd_k];
      a_q_r <= a_mem[rd_k];
    end
  end

  // Delay line store.
  always_ff @(posedge clk) begin
    if (d_we) begin
      d_mem[d_wa] <= d_clip;
    end
    if (d_rd_en) begin
      d_q_r <= d_mem[DAW'(rd_k)];
    end
  end

  // Valid bits stand in for the zero reset of the stores.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= '0;
      a_vld_r <= '0;
      d_vld_r <= '0;
      b_v_r   <= 1'b0;
      a_v_r   <= 1'b0;
      d_v_r   <= 1'b0;
      dsel_r  <= 1'b0;
    end else begin
      if (b_we) begin
        b_vld_r[wa] <= 1'b1;
      end
      if (a_we) begin
        a_vld_r[wa] <= 1'b1;
      end
      if (d_clr) begin
        d_vld_r <= '0;
      end else if (d_we) begin
        d_vld_r[d_wa] <= 1'b1;
      end
      if (rd_en) begin
        b_v_r  <= b_vld_r[rd_k];
        a_v_r  <= a_vld_r[rd_k];
        dsel_r <= d_rd_en;
      end
      if (d_rd_en) begin
        d_v_r <= d_vld_r[DAW'(rd_k)];
      end
    end
  end

  assign b_val = b_v_r ? b_q_r : '0;
  assign a_val = a_v_r ? a_q_r : '0;
  assign dterm = (dsel_r && d_v_r) ? d_q_r : '0;

  // Multiply-accumulate control: b*x, then a*y while the b product loads.
  always_comb begin
    mac_ctl.mul_en = (state_r == S_MB) || (state_r == S_MA);
    case (state_r)
      S_MA:    mac_ctl.acc_op = ACC_LOAD;
      S_AC:    mac_ctl.acc_op = (k_r == '0) ? ACC_HOLD : ACC_SUB;
      default: mac_ctl.acc_op = ACC_HOLD;
    endcase
  end

  assign mac_coef = (state_r == S_MA) ? a_val : b_val;
  assign mac_mult = (state_r == S_MA) ? y_r : x_r;

  iirdf2_mac u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .coef   (mac_coef),
    .mult   (mac_mult),
    .addend (dterm),
    .acc    (acc)
  );

  // Output sample: round half up, then saturate to Q1.15.
  always_comb begin
    y_sum  = acc + ROUND_HALF;
    y_full = y_sum >>> Y_SHIFT;
    if (y_full > ACC_W'(Y_MAX)) begin
      y_sat  = Y_MAX;
      y_clip = 1'b1;
    end else if (y_full < ACC_W'(Y_MIN)) begin
      y_sat  = Y_MIN;
      y_clip = 1'b1;
    end else begin
      y_sat  = SAMP_W'(y_full);
      y_clip = 1'b0;
    end
  end

  // Delay word saturation to Q17.39.
  always_comb begin
    if (acc > ACC_W'(DW_MAX)) begin
      d_clip    = DW_MAX;
      d_clipped = 1'b1;
    end else if (acc < ACC_W'(DW_MIN)) begin
      d_clip    = DW_MIN;
      d_clipped = 1'b1;
    end else begin
      d_clip    = DW'(acc);
      d_clipped = 1'b0;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_data.command == CMD_FILTER)) begin
          state_nxt = S_MB;
          k_nxt     = '0;
          n_nxt     = n_eff;
          x_nxt     = in_data.sample_in;
          flag_nxt  = 1'b0;
        end
      end
      S_MB: state_nxt = S_MA;
      S_MA: state_nxt = S_AC;
      S_AC: state_nxt = S_WB;
      S_WB: begin
        if (k_r == '0) begin
          y_nxt    = y_sat;
          flag_nxt = flag_r | y_clip;
        end else begin
          flag_nxt = flag_r | d_clipped;
        end
        if (k_r == n_r) begin
          state_nxt = S_FIN;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_MB;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.filtered_sample = y_r;
          out_data_nxt.saturated       = flag_r;
          state_nxt                    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      n_r         <= KW'(1);
      out_valid_r <= 1'b0;
      cfg_order_r <= ORDER_CFG_RST;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_order_r <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    flag_r     <= flag_nxt;
    out_data_r <= out_data_nxt;
  end

  // The tap counter never passes the latched order while a sample is in work.
  a_tap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> ((k_r <= n_r) && (n_r != '0)))
    else $error("tap counter beyond active order");

  // An accepted filter command blocks further input on the next cycle.
  a_busy_after_filter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_data.command == CMD_FILTER)) |=> in_stall)
    else $error("input not stalled while filtering");

  // A new result appears only from the final state of the sequence.
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside final state");

  // Delay words are written back only inside the active order.
  a_write_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    d_we |-> ((k_r - 1'b1) < n_r))
    else $error("delay word written beyond active order");

endmodule
